// ===== rtl/core/rpn_eval_pkg.sv =====
// Shared types, character codes and helpers for the postfix evaluator.
// No dependencies; the ALU and the evaluator unit refer to this package, the stack does not.
`timescale 1ns / 1ps

package rpn_eval_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DEFAULT_WORD_WIDTH  = 32;
    localparam int SYM_W               = 8;
    localparam int VALUE_W             = 32;
    localparam int STATUS_W            = 3;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_BAD   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_ALU,
        S_POW,
        S_POW_MR,
        S_POW_MS,
        S_PUSH,
        S_FINISH,
        S_FIN_RD
    } t_state;

    function automatic logic is_digit(input logic [SYM_W-1:0] sym);
        return (sym >= CH_ZERO) && (sym <= CH_NINE);
    endfunction

    function automatic logic is_oper(input logic [SYM_W-1:0] sym);
        return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) ||
               (sym == CH_SLASH) || (sym == CH_CARET);
    endfunction

endpackage

// ===== rtl/core/rpn_eval_stack.sv =====
// Operand stack storage: one write port, one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rpn_eval_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH  = 32,
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WORD_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [WORD_WIDTH-1:0] o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rpn_eval_alu.sv =====
// Shared arithmetic unit: registered add/subtract, bit-serial shift-add multiply
// and restoring signed divide (one bit per cycle). Uses rpn_eval_pkg.
`timescale 1ns / 1ps

module rpn_eval_alu #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rpn_eval_pkg::t_alu_req  i_req,
    input  logic [WORD_WIDTH-1:0]   i_a,
    input  logic [WORD_WIDTH-1:0]   i_b,
    output logic                    o_done,
    output logic [WORD_WIDTH-1:0]   o_result
);

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    rpn_eval_pkg::t_alu_op r_op;
    logic                  r_neg;
    logic [W-1:0]          r_acc;
    logic [W-1:0]          r_x;
    logic [W-1:0]          r_y;

    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] trial;

    assign mag_a = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign mag_b = i_b[W-1] ? (W'(0) - i_b) : i_b;
    // remainder stays below the divisor, so the shifted value fits in W bits
    assign trial = {r_acc[W-2:0], r_y[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= (i_req.op == rpn_eval_pkg::ALU_MUL) ||
                      (i_req.op == rpn_eval_pkg::ALU_DIV);
            r_done <= (i_req.op == rpn_eval_pkg::ALU_ADD) ||
                      (i_req.op == rpn_eval_pkg::ALU_SUB);
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= CW'(W - 1);
            r_neg <= i_a[W-1] ^ i_b[W-1];
            case (i_req.op)
                rpn_eval_pkg::ALU_ADD: begin
                    r_acc <= i_a + i_b;
                end
                rpn_eval_pkg::ALU_SUB: begin
                    r_acc <= i_a - i_b;
                end
                rpn_eval_pkg::ALU_MUL: begin
                    r_acc <= '0;
                    r_x   <= i_a;
                    r_y   <= i_b;
                end
                default: begin
                    r_acc <= '0;
                    r_x   <= mag_b;
                    r_y   <= mag_a;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_op == rpn_eval_pkg::ALU_MUL) begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[W-2:0], 1'b0};
                r_y <= {1'b0, r_y[W-1:1]};
            end else begin
                if (trial >= r_x) begin
                    r_acc <= trial - r_x;
                    r_y   <= {r_y[W-2:0], 1'b1};
                end else begin
                    r_acc <= trial;
                    r_y   <= {r_y[W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op != rpn_eval_pkg::ALU_DIV) ? r_acc :
                      (r_neg ? (W'(0) - r_y) : r_y);

endmodule

// ===== rtl/core/postfix_expression_evaluator_unit.sv =====
// Postfix evaluator: a digit is pushed at DECODE; + - * / read both operands and run the ALU
// (* and / bit-serial); ^ uses square-and-multiply on the ALU, a zero exponent pushes one directly.
// One item in flight; ready only in IDLE. A last item adds a top-of-stack read plus any output wait.
// Reset (i_rst_n low, synchronous) empties the stack, clears the status and the output valid.
// The stack RAM is not cleared; only entries below the stack pointer are ever used.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = rpn_eval_pkg::DEFAULT_STACK_DEPTH,
    parameter int WORD_WIDTH  = rpn_eval_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel: one character per item
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [rpn_eval_pkg::SYM_W-1:0]       i_symbol,
    input  logic                                 i_last,
    // result channel: one item per expression
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [rpn_eval_pkg::VALUE_W-1:0] o_value,
    output logic [rpn_eval_pkg::STATUS_W-1:0]    o_status
);

    localparam int W  = WORD_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);

    // sequencer state
    rpn_eval_pkg::t_state  r_state, n_state;
    logic [SW-1:0]         r_sp, n_sp;
    rpn_eval_pkg::t_status r_status, n_status;
    // latched item
    logic [rpn_eval_pkg::SYM_W-1:0] r_sym, n_sym;
    logic                  r_last, n_last;
    // operands and power loop
    logic [W-1:0]          r_a, n_a;
    logic [W-1:0]          r_b, n_b;
    logic [W-1:0]          r_res, n_res;
    logic [W-1:0]          r_sq, n_sq;
    logic [W-1:0]          r_ex, n_ex;
    // output register
    logic                  r_out_valid, n_out_valid;
    logic [rpn_eval_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    rpn_eval_pkg::t_status r_out_status, n_out_status;

    // stack port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [W-1:0]          mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [W-1:0]          mem_rdata;

    // ALU port
    rpn_eval_pkg::t_alu_req alu_req;
    logic [W-1:0]          alu_a;
    logic [W-1:0]          alu_b;
    logic                  alu_done;
    logic [W-1:0]          alu_result;

    logic [SW-1:0]         sp_m1;
    logic [SW-1:0]         sp_m2;
    logic                  out_free;

    assign sp_m1    = r_sp - SW'(1);
    assign sp_m2    = r_sp - SW'(2);
    assign out_free = !r_out_valid || i_ready;

    rpn_eval_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    rpn_eval_alu #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_result(alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpn_eval_pkg::S_IDLE;
            r_sp        <= '0;
            r_status    <= rpn_eval_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_a          <= n_a;
        r_b          <= n_b;
        r_res        <= n_res;
        r_sq         <= n_sq;
        r_ex         <= n_ex;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_status     = r_status;
        n_sym        = r_sym;
        n_last       = r_last;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_sq         = r_sq;
        n_ex         = r_ex;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        mem_we       = 1'b0;
        mem_waddr    = r_sp[AW-1:0];
        mem_wdata    = r_res;
        // top of stack by default; held through FIN_RD so a stalled output sees stable data
        mem_raddr    = sp_m1[AW-1:0];

        alu_req.start = 1'b0;
        alu_req.op    = rpn_eval_pkg::ALU_ADD;
        alu_a         = r_a;
        alu_b         = r_b;

        case (r_state)
            rpn_eval_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_symbol;
                    n_last  = i_last;
                    n_state = rpn_eval_pkg::S_DECODE;
                end
            end

            rpn_eval_pkg::S_DECODE: begin
                n_state = rpn_eval_pkg::S_FINISH;
                if (rpn_eval_pkg::is_digit(r_sym)) begin
                    if (r_sp >= SW'(STACK_DEPTH)) begin
                        // full: drop the digit
                        if (r_status == rpn_eval_pkg::ST_OK) begin
                            n_status = rpn_eval_pkg::ST_OVER;
                        end
                    end else begin
                        // low nibble of an ASCII digit is its value
                        mem_we    = 1'b1;
                        mem_wdata = W'(r_sym[3:0]);
                        n_sp      = r_sp + SW'(1);
                    end
                end else if (rpn_eval_pkg::is_oper(r_sym)) begin
                    if (r_sp < SW'(2)) begin
                        if (r_status == rpn_eval_pkg::ST_OK) begin
                            n_status = rpn_eval_pkg::ST_UNDER;
                        end
                    end else begin
                        // read of the right operand was issued this cycle
                        n_state = rpn_eval_pkg::S_RD_B;
                    end
                end else begin
                    if (r_status == rpn_eval_pkg::ST_OK) begin
                        n_status = rpn_eval_pkg::ST_BAD;
                    end
                end
            end

            rpn_eval_pkg::S_RD_B: begin
                n_b       = mem_rdata;
                mem_raddr = sp_m2[AW-1:0];
                n_state   = rpn_eval_pkg::S_RD_A;
            end

            rpn_eval_pkg::S_RD_A: begin
                n_a     = mem_rdata;
                n_sp    = sp_m2;
                n_state = rpn_eval_pkg::S_EXEC;
            end

            rpn_eval_pkg::S_EXEC: begin
                n_state = rpn_eval_pkg::S_ALU;
                case (r_sym)
                    rpn_eval_pkg::CH_PLUS: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = rpn_eval_pkg::ALU_ADD;
                    end
                    rpn_eval_pkg::CH_MINUS: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = rpn_eval_pkg::ALU_SUB;
                    end
                    rpn_eval_pkg::CH_STAR: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = rpn_eval_pkg::ALU_MUL;
                    end
                    rpn_eval_pkg::CH_SLASH: begin
                        if (r_b == '0) begin
                            // divide by zero: push zero
                            n_res   = '0;
                            n_state = rpn_eval_pkg::S_PUSH;
                            if (r_status == rpn_eval_pkg::ST_OK) begin
                                n_status = rpn_eval_pkg::ST_DIVZ;
                            end
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = rpn_eval_pkg::ALU_DIV;
                        end
                    end
                    default: begin
                        // power
                        if (r_b[W-1]) begin
                            // negative exponent: only bases of one and minus one survive
                            n_state = rpn_eval_pkg::S_PUSH;
                            if (r_a == W'(1)) begin
                                n_res = W'(1);
                            end else if (r_a == '1) begin
                                n_res = r_b[0] ? '1 : W'(1);
                            end else begin
                                n_res = '0;
                            end
                        end else begin
                            n_res   = W'(1);
                            n_sq    = r_a;
                            n_ex    = r_b;
                            n_state = rpn_eval_pkg::S_POW;
                        end
                    end
                endcase
            end

            rpn_eval_pkg::S_ALU: begin
                if (alu_done) begin
                    n_res   = alu_result;
                    n_state = rpn_eval_pkg::S_PUSH;
                end
            end

            rpn_eval_pkg::S_POW: begin
                alu_req.op = rpn_eval_pkg::ALU_MUL;
                if (r_ex == '0) begin
                    n_state = rpn_eval_pkg::S_PUSH;
                end else if (r_ex[0]) begin
                    // fold the current square into the result
                    alu_req.start = 1'b1;
                    alu_a         = r_res;
                    alu_b         = r_sq;
                    n_state       = rpn_eval_pkg::S_POW_MR;
                end else begin
                    alu_req.start = 1'b1;
                    alu_a         = r_sq;
                    alu_b         = r_sq;
                    n_state       = rpn_eval_pkg::S_POW_MS;
                end
            end

            rpn_eval_pkg::S_POW_MR: begin
                alu_req.op = rpn_eval_pkg::ALU_MUL;
                alu_a      = r_sq;
                alu_b      = r_sq;
                if (alu_done) begin
                    n_res = alu_result;
                    if (r_ex[W-1:1] == '0) begin
                        // last exponent bit: skip the final squaring
                        n_state = rpn_eval_pkg::S_PUSH;
                    end else begin
                        alu_req.start = 1'b1;
                        n_state       = rpn_eval_pkg::S_POW_MS;
                    end
                end
            end

            rpn_eval_pkg::S_POW_MS: begin
                if (alu_done) begin
                    n_sq    = alu_result;
                    n_ex    = {1'b0, r_ex[W-1:1]};
                    n_state = rpn_eval_pkg::S_POW;
                end
            end

            rpn_eval_pkg::S_PUSH: begin
                mem_we    = 1'b1;
                mem_wdata = r_res;
                n_sp      = r_sp + SW'(1);
                n_state   = rpn_eval_pkg::S_FINISH;
            end

            rpn_eval_pkg::S_FINISH: begin
                if (!r_last) begin
                    n_state = rpn_eval_pkg::S_IDLE;
                end else if (r_sp == '0) begin
                    // empty stack at the end: emit zero with underflow unless flagged earlier
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_status = (r_status == rpn_eval_pkg::ST_OK) ?
                                       rpn_eval_pkg::ST_UNDER : r_status;
                        n_sp         = '0;
                        n_status     = rpn_eval_pkg::ST_OK;
                        n_state      = rpn_eval_pkg::S_IDLE;
                    end
                end else begin
                    n_state = rpn_eval_pkg::S_FIN_RD;
                end
            end

            rpn_eval_pkg::S_FIN_RD: begin
                // hold here until the output register frees up
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = rpn_eval_pkg::VALUE_W'($signed(mem_rdata));
                    n_out_status = r_status;
                    n_sp         = '0;
                    n_status     = rpn_eval_pkg::ST_OK;
                    n_state      = rpn_eval_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rpn_eval_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready  = (r_state == rpn_eval_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule
